// ----- design/smrg_pkg.sv -----
package smrg_pkg;

    // Field widths fixed by the interface.
    localparam int SIZE_W    = 9;
    localparam int COORD_W   = 8;
    localparam int IDX_W     = 24;
    localparam int COEFF_W   = 6;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 2;

    // Internal widths: x/y/z sizes never exceed 511, so nx*ny fits 18 bits
    // and y*nx fits 17 bits.
    localparam int PLANE_W = 2 * SIZE_W;
    localparam int YOFF_W  = COORD_W + SIZE_W;
    localparam int ROWS_W  = COORD_W + PLANE_W;

    localparam int DEFAULT_MAX_DIM = 256;

    // Row jobs held between the front and the back part.
    localparam int Q_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEVEN  = 2'd3;

    // Offset codes along one axis.
    typedef logic [1:0] ofs_t;
    localparam ofs_t OFS_NEG = 2'd0;
    localparam ofs_t OFS_MID = 2'd1;
    localparam ofs_t OFS_POS = 2'd2;

    localparam logic signed [COEFF_W-1:0] COEFF_DIAG = 6'sd27;
    localparam logic signed [COEFF_W-1:0] COEFF_OFF  = -6'sd1;
    localparam logic [CNT_W:0]            RHS_BASE   = 6'd28;

    typedef struct packed {
        logic [SIZE_W-1:0]  nx;
        logic [SIZE_W-1:0]  ny;
        logic [SIZE_W-1:0]  nz;
        logic [PLANE_W-1:0] plane;
        logic               seven;
    } grid_cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic             bad;
        logic             xm;
        logic             xp;
        logic             ym;
        logic             yp;
        logic             zm;
        logic             zp;
        logic [CNT_W-1:0] cnt;
        ofs_t             lx;
        ofs_t             ly;
        ofs_t             lz;
    } row_job_t;

endpackage

// ----- design/stencil_matrix_row_generator.sv -----
// Matrix-free row generator for the 3D 7-point or 27-point stencil matrix.
// Push one grid point (point_x, point_y, point_z); the block returns one
// result per nonzero of that point's row, its in-grid neighbours in the
// order z offset, then y offset, then x offset (x fastest), each with the
// linear column index z*nx*ny + y*nx + x (kept to 24 bits) and coefficient
// 27 on the diagonal, -1 elsewhere. The last result of a row has last set
// and carries the nonzero count and the right-hand side 28 minus the count.
// A point outside the configured grid returns a single result with
// bad_request and last set and all other fields zero. Sizes above MAX_DIM
// act as MAX_DIM; a size of zero makes every request bad. The back
// sequencer walks a row's stencil offsets one per step, from the corner
// offset up to the row's last in-grid neighbour (a bad request takes a
// single step); a step on an offset that is not a nonzero gives no result,
// and no step is taken while the output register holds a result that is
// not being popped. The first result of a request passes the front's
// stage register, the row queue and the output register; it also waits for
// offsets skipped before the first in-grid neighbour, and for older rows.
// Up to four requests may be in flight, so several pushes are taken while
// a row is still being emitted. Configuration is written while no request
// is outstanding.
module stencil_matrix_row_generator
    import smrg_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [SIZE_W-1:0]          cfg_data,
    input  logic                       push,
    output logic                       full,
    input  logic [COORD_W-1:0]         point_x,
    input  logic [COORD_W-1:0]         point_y,
    input  logic [COORD_W-1:0]         point_z,
    output logic                       empty,
    input  logic                       pop,
    output logic [IDX_W-1:0]           row_index,
    output logic [IDX_W-1:0]           col_index,
    output logic signed [COEFF_W-1:0]  coeff,
    output logic                       is_diagonal,
    output logic [CNT_W-1:0]           row_count,
    output logic [CNT_W-1:0]           rhs_value,
    output logic                       last,
    output logic                       bad_request
);

    logic [SIZE_W-1:0]  size_x_reg;
    logic [SIZE_W-1:0]  size_y_reg;
    logic [SIZE_W-1:0]  size_z_reg;
    logic               seven_reg;
    logic [PLANE_W-1:0] plane_reg;

    logic [SIZE_W-1:0]  nx_eff;
    logic [SIZE_W-1:0]  ny_eff;
    logic [SIZE_W-1:0]  nz_eff;
    grid_cfg_t          cfg;

    logic               job_push;
    row_job_t           job_in;
    logic               job_valid;
    row_job_t           job_head;
    logic               job_done;

    // Configuration registers. Every index in the port's range names one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_W'(1);
            size_y_reg <= SIZE_W'(1);
            size_z_reg <= SIZE_W'(1);
            seven_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SIZE_X: size_x_reg <= cfg_data;
                REG_SIZE_Y: size_y_reg <= cfg_data;
                REG_SIZE_Z: size_z_reg <= cfg_data;
                REG_SEVEN:  seven_reg  <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Sizes clamp to the largest supported grid.
    assign nx_eff = (32'(size_x_reg) > MAX_DIM) ? SIZE_W'(MAX_DIM) : size_x_reg;
    assign ny_eff = (32'(size_y_reg) > MAX_DIM) ? SIZE_W'(MAX_DIM) : size_y_reg;
    assign nz_eff = (32'(size_z_reg) > MAX_DIM) ? SIZE_W'(MAX_DIM) : size_z_reg;

    // The plane size nx*ny is registered every cycle. The front part first
    // reads it in the cycle after a request is accepted, so a request pushed
    // right after a size write still sees the new plane.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= PLANE_W'(1);
        end
        else
        begin
            plane_reg <= PLANE_W'(nx_eff) * PLANE_W'(ny_eff);
        end
    end

    always_comb
    begin
        cfg.nx    = nx_eff;
        cfg.ny    = ny_eff;
        cfg.nz    = nz_eff;
        cfg.plane = plane_reg;
        cfg.seven = seven_reg;
    end

    // Front: takes requests, checks bounds, forms the row index and the
    // neighbour summary (which sides exist, count, last offset).
    smrg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .push     (push),
        .full     (full),
        .point_x  (point_x),
        .point_y  (point_y),
        .point_z  (point_z),
        .job_done (job_done),
        .job_push (job_push),
        .job      (job_in)
    );

    // Short queue of classified rows between the two halves.
    smrg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_job   (job_in),
        .rd_en    (job_done),
        .rd_valid (job_valid),
        .rd_job   (job_head)
    );

    // Back: walks the stencil offsets of the row at the queue head and
    // delivers each nonzero through an output register.
    smrg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .job_valid   (job_valid),
        .job         (job_head),
        .job_done    (job_done),
        .empty       (empty),
        .pop         (pop),
        .row_index   (row_index),
        .col_index   (col_index),
        .coeff       (coeff),
        .is_diagonal (is_diagonal),
        .row_count   (row_count),
        .rhs_value   (rhs_value),
        .last        (last),
        .bad_request (bad_request)
    );

endmodule

// ----- design/smrg_front.sv -----
module smrg_front
    import smrg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  grid_cfg_t          cfg,
    input  logic               push,
    output logic               full,
    input  logic [COORD_W-1:0] point_x,
    input  logic [COORD_W-1:0] point_y,
    input  logic [COORD_W-1:0] point_z,
    input  logic               job_done,
    output logic               job_push,
    output row_job_t           job
);

    localparam int OCC_W = $clog2(Q_DEPTH + 1);

    logic [OCC_W-1:0]   occ_reg;
    logic               v1_reg;
    logic [COORD_W-1:0] x1_reg;
    logic [COORD_W-1:0] y1_reg;
    logic [COORD_W-1:0] z1_reg;
    logic [YOFF_W-1:0]  yoff1_reg;
    logic               bad1_reg;

    logic               accept;
    logic [ROWS_W-1:0]  row_sum;
    logic [SIZE_W-1:0]  x_inc;
    logic [SIZE_W-1:0]  y_inc;
    logic [SIZE_W-1:0]  z_inc;
    logic [1:0]         cx;
    logic [1:0]         cy;
    logic [1:0]         cz;
    logic [CNT_W-1:0]   cnt27;
    logic [CNT_W-1:0]   cnt7;

    // Credits cover both the stage register and the queue, so the queue
    // can never overflow.
    assign full   = (occ_reg == OCC_W'(Q_DEPTH));
    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
            v1_reg  <= 1'b0;
        end
        else
        begin
            if (accept && !job_done)
            begin
                occ_reg <= occ_reg + OCC_W'(1);
            end
            else if (!accept && job_done)
            begin
                occ_reg <= occ_reg - OCC_W'(1);
            end
            v1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x1_reg    <= point_x;
            y1_reg    <= point_y;
            z1_reg    <= point_z;
            yoff1_reg <= YOFF_W'(point_y) * YOFF_W'(cfg.nx);
            bad1_reg  <= (SIZE_W'(point_x) >= cfg.nx) || (SIZE_W'(point_y) >= cfg.ny)
                      || (SIZE_W'(point_z) >= cfg.nz);
        end
    end

    assign row_sum = ROWS_W'(z1_reg) * ROWS_W'(cfg.plane) + ROWS_W'(yoff1_reg)
                   + ROWS_W'(x1_reg);
    assign x_inc   = SIZE_W'(x1_reg) + SIZE_W'(1);
    assign y_inc   = SIZE_W'(y1_reg) + SIZE_W'(1);
    assign z_inc   = SIZE_W'(z1_reg) + SIZE_W'(1);

    always_comb
    begin
        job      = '0;
        job.bad  = bad1_reg;
        job.row  = row_sum[IDX_W-1:0];
        job.xm   = (x1_reg != '0);
        job.ym   = (y1_reg != '0);
        job.zm   = (z1_reg != '0);
        job.xp   = (x_inc < cfg.nx);
        job.yp   = (y_inc < cfg.ny);
        job.zp   = (z_inc < cfg.nz);

        cx    = 2'd1 + 2'(job.xm) + 2'(job.xp);
        cy    = 2'd1 + 2'(job.ym) + 2'(job.yp);
        cz    = 2'd1 + 2'(job.zm) + 2'(job.zp);
        cnt27 = CNT_W'(cx) * CNT_W'(cy) * CNT_W'(cz);
        cnt7  = CNT_W'(1) + CNT_W'(job.xm) + CNT_W'(job.xp) + CNT_W'(job.ym)
              + CNT_W'(job.yp) + CNT_W'(job.zm) + CNT_W'(job.zp);

        if (cfg.seven)
        begin
            job.cnt = cnt7;
            job.lx  = OFS_MID;
            job.ly  = OFS_MID;
            job.lz  = OFS_MID;
            if (job.zp)
            begin
                job.lz = OFS_POS;
            end
            else if (job.yp)
            begin
                job.ly = OFS_POS;
            end
            else if (job.xp)
            begin
                job.lx = OFS_POS;
            end
        end
        else
        begin
            job.cnt = cnt27;
            job.lx  = job.xp ? OFS_POS : OFS_MID;
            job.ly  = job.yp ? OFS_POS : OFS_MID;
            job.lz  = job.zp ? OFS_POS : OFS_MID;
        end
    end

    assign job_push = v1_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(Q_DEPTH))
        else $error("front credit count exceeds queue depth");

    a_done_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        job_done |-> occ_reg != '0)
        else $error("row finished with no request outstanding");

endmodule

// ----- design/smrg_queue.sv -----
module smrg_queue
    import smrg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  row_job_t wr_job,
    input  logic     rd_en,
    output logic     rd_valid,
    output row_job_t rd_job
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_QW = $clog2(Q_DEPTH + 1);

    row_job_t           slot_reg [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_QW-1:0]  cnt_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + CNT_QW'(1);
            end
            else if (!wr_en && rd_en)
            begin
                cnt_reg <= cnt_reg - CNT_QW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

    assign rd_valid = (cnt_reg != '0);
    assign rd_job   = slot_reg[rd_ptr_reg];

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && !rd_en |-> cnt_reg != CNT_QW'(Q_DEPTH))
        else $error("row queue written while full");

endmodule

// ----- design/smrg_back.sv -----
module smrg_back
    import smrg_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  grid_cfg_t                  cfg,
    input  logic                       job_valid,
    input  row_job_t                   job,
    output logic                       job_done,
    output logic                       empty,
    input  logic                       pop,
    output logic [IDX_W-1:0]           row_index,
    output logic [IDX_W-1:0]           col_index,
    output logic signed [COEFF_W-1:0]  coeff,
    output logic                       is_diagonal,
    output logic [CNT_W-1:0]           row_count,
    output logic [CNT_W-1:0]           rhs_value,
    output logic                       last,
    output logic                       bad_request
);

    ofs_t cx_reg;
    ofs_t cy_reg;
    ofs_t cz_reg;
    logic out_valid_reg;

    logic                      out_ready;
    logic                      step;
    logic                      at_last;
    logic                      x_ok;
    logic                      y_ok;
    logic                      z_ok;
    logic [1:0]                off_axes;
    logic                      cell_ok;
    logic                      diag;
    logic                      emit;
    logic [IDX_W-1:0]          tx;
    logic [IDX_W-1:0]          ty;
    logic [IDX_W-1:0]          tz;
    logic [IDX_W-1:0]          col_next;
    ofs_t                      cx_next;
    ofs_t                      cy_next;
    ofs_t                      cz_next;

    assign out_ready = !out_valid_reg || pop;
    assign step      = job_valid && out_ready;

    assign at_last  = (cx_reg == job.lx) && (cy_reg == job.ly) && (cz_reg == job.lz);
    assign x_ok     = (cx_reg == OFS_NEG) ? job.xm : ((cx_reg == OFS_POS) ? job.xp : 1'b1);
    assign y_ok     = (cy_reg == OFS_NEG) ? job.ym : ((cy_reg == OFS_POS) ? job.yp : 1'b1);
    assign z_ok     = (cz_reg == OFS_NEG) ? job.zm : ((cz_reg == OFS_POS) ? job.zp : 1'b1);
    assign off_axes = 2'(cx_reg != OFS_MID) + 2'(cy_reg != OFS_MID) + 2'(cz_reg != OFS_MID);
    assign cell_ok  = x_ok && y_ok && z_ok && !(cfg.seven && (off_axes > 2'd1));
    assign diag     = (off_axes == 2'd0);
    assign emit     = step && (job.bad || cell_ok);
    assign job_done = step && (job.bad || at_last);

    // Column offset terms, modulo 2^24 like the index itself.
    always_comb
    begin
        case (cx_reg)
            OFS_NEG: tx = '1;
            OFS_POS: tx = IDX_W'(1);
            default: tx = '0;
        endcase
        case (cy_reg)
            OFS_NEG: ty = IDX_W'(0) - IDX_W'(cfg.nx);
            OFS_POS: ty = IDX_W'(cfg.nx);
            default: ty = '0;
        endcase
        case (cz_reg)
            OFS_NEG: tz = IDX_W'(0) - IDX_W'(cfg.plane);
            OFS_POS: tz = IDX_W'(cfg.plane);
            default: tz = '0;
        endcase
        col_next = job.row + tx + ty + tz;
    end

    always_comb
    begin
        cx_next = cx_reg;
        cy_next = cy_reg;
        cz_next = cz_reg;
        if (job_done)
        begin
            cx_next = OFS_NEG;
            cy_next = OFS_NEG;
            cz_next = OFS_NEG;
        end
        else if (step)
        begin
            if (cx_reg != OFS_POS)
            begin
                cx_next = cx_reg + 2'd1;
            end
            else
            begin
                cx_next = OFS_NEG;
                if (cy_reg != OFS_POS)
                begin
                    cy_next = cy_reg + 2'd1;
                end
                else
                begin
                    cy_next = OFS_NEG;
                    cz_next = cz_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg        <= OFS_NEG;
            cy_reg        <= OFS_NEG;
            cz_reg        <= OFS_NEG;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            cz_reg <= cz_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if (job.bad)
            begin
                row_index   <= '0;
                col_index   <= '0;
                coeff       <= '0;
                is_diagonal <= 1'b0;
                row_count   <= '0;
                rhs_value   <= '0;
                last        <= 1'b1;
                bad_request <= 1'b1;
            end
            else
            begin
                row_index   <= job.row;
                col_index   <= col_next;
                coeff       <= diag ? COEFF_DIAG : COEFF_OFF;
                is_diagonal <= diag;
                row_count   <= at_last ? job.cnt : '0;
                rhs_value   <= at_last ? CNT_W'(RHS_BASE - (CNT_W + 1)'(job.cnt)) : '0;
                last        <= at_last;
                bad_request <= 1'b0;
            end
        end
    end

    assign empty = !out_valid_reg;

    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && bad_request |-> last && row_count == '0)
        else $error("bad request result not a lone last result");

    a_last_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last && !bad_request |-> row_count != '0)
        else $error("last result of a row carries no count");

    a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
        job_done |=> out_valid_reg && last)
        else $error("row finished without its last result");

endmodule

// ----- tb/sv/stencil_check_pkg.sv -----
package stencil_check_pkg;

    import smrg_pkg::*;

    // One nonzero of a matrix row as it leaves the block.
    typedef struct packed {
        logic [IDX_W-1:0]          row_index;
        logic [IDX_W-1:0]          col_index;
        logic signed [COEFF_W-1:0] coeff;
        logic                      is_diagonal;
        logic [CNT_W-1:0]          row_count;
        logic [CNT_W-1:0]          rhs_value;
        logic                      last;
        logic                      bad_request;
    } stencil_entry_t;

    // Keeps its own copy of the grid registers, expands each accepted grid
    // point into the row entries it must produce and checks them in order.
    class stencil_row_scoreboard;

        stencil_entry_t expected_entries[$];
        int unsigned    grid_x;
        int unsigned    grid_y;
        int unsigned    grid_z;
        bit             seven_point;
        int unsigned    mismatches;
        int unsigned    entries_checked;
        int unsigned    points_noted;
        int unsigned    bad_points_noted;

        function new();
            grid_x           = 1;
            grid_y           = 1;
            grid_z           = 1;
            seven_point      = 1'b0;
            mismatches       = 0;
            entries_checked  = 0;
            points_noted     = 0;
            bad_points_noted = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [SIZE_W-1:0] data);
            case (index)
                REG_SIZE_X: grid_x = 32'(data);
                REG_SIZE_Y: grid_y = 32'(data);
                REG_SIZE_Z: grid_z = 32'(data);
                REG_SEVEN:  seven_point = data[0];
                default:    ;
            endcase
        endfunction

        function int clamp_dim(int unsigned n);
            return (n > DEFAULT_MAX_DIM) ? DEFAULT_MAX_DIM : int'(n);
        endfunction

        function int pending();
            return expected_entries.size();
        endfunction

        function void note_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                 logic [COORD_W-1:0] z);
            int             nx;
            int             ny;
            int             nz;
            int             px;
            int             py;
            int             pz;
            int             n;
            longint         lin;
            logic           diag;
            stencil_entry_t e;
            stencil_entry_t row_entries[$];
            nx = clamp_dim(grid_x);
            ny = clamp_dim(grid_y);
            nz = clamp_dim(grid_z);
            points_noted++;
            if (int'(x) >= nx || int'(y) >= ny || int'(z) >= nz) begin
                e             = '0;
                e.last        = 1'b1;
                e.bad_request = 1'b1;
                expected_entries.push_back(e);
                bad_points_noted++;
                return;
            end
            lin = longint'(z) * nx * ny + longint'(y) * nx + longint'(x);
            for (int dz = -1; dz <= 1; dz++) begin
                for (int dy = -1; dy <= 1; dy++) begin
                    for (int dx = -1; dx <= 1; dx++) begin
                        px = int'(x) + dx;
                        py = int'(y) + dy;
                        pz = int'(z) + dz;
                        if (px < 0 || px >= nx || py < 0 || py >= ny || pz < 0 || pz >= nz)
                            continue;
                        if (seven_point && (dx * dx + dy * dy + dz * dz) > 1)
                            continue;
                        diag          = (dx == 0 && dy == 0 && dz == 0);
                        e             = '0;
                        e.row_index   = lin[IDX_W-1:0];
                        e.col_index   = IDX_W'(longint'(pz) * nx * ny + longint'(py) * nx + px);
                        e.coeff       = diag ? COEFF_DIAG : COEFF_OFF;
                        e.is_diagonal = diag;
                        row_entries.push_back(e);
                    end
                end
            end
            n = row_entries.size();
            row_entries[n-1].row_count = CNT_W'(n);
            row_entries[n-1].rhs_value = CNT_W'(28 - n);
            row_entries[n-1].last      = 1'b1;
            foreach (row_entries[i])
                expected_entries.push_back(row_entries[i]);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_entry(stencil_entry_t got);
            stencil_entry_t want;
            if (expected_entries.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual row %0d col %0d",
                         $time, got.row_index, got.col_index);
                return;
            end
            want = expected_entries.pop_front();
            entries_checked++;
            compare_field("row_index", longint'(want.row_index), longint'(got.row_index));
            compare_field("col_index", longint'(want.col_index), longint'(got.col_index));
            compare_field("coeff", longint'(want.coeff), longint'(got.coeff));
            compare_field("is_diagonal", longint'(want.is_diagonal),
                          longint'(got.is_diagonal));
            compare_field("row_count", longint'(want.row_count), longint'(got.row_count));
            compare_field("rhs_value", longint'(want.rhs_value), longint'(got.rhs_value));
            compare_field("last", longint'(want.last), longint'(got.last));
            compare_field("bad_request", longint'(want.bad_request),
                          longint'(got.bad_request));
        endfunction

    endclass

endpackage

// ----- tb/sv/tb.sv -----
module tb;

    import smrg_pkg::*;
    import stencil_check_pkg::*;

    // Share of cycles in which each side idles while idling is enabled.
    localparam int IDLE_PCT       = 26;
    // Length of the one long stall of the result side.
    localparam int HOLD_CYCLES    = 300;
    // Cycles without any accepted request before the run is declared hung.
    // The slowest correct stretch is the long result stall above.
    localparam int WATCHDOG_LIMIT = 4000;
    // Quiet cycles allowed after the last result before touching registers
    // or ending the run.
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_PHASES  = 16;
    localparam int PHASE_POINTS   = 27;
    // Phases with special treatment of the handshakes.
    localparam int HOLD_PHASE     = 2;
    localparam int STEADY_PHASE   = 5;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [SIZE_W-1:0]         cfg_data = '0;
    logic                      push = 1'b0;
    logic                      full;
    logic [COORD_W-1:0]        point_x = '0;
    logic [COORD_W-1:0]        point_y = '0;
    logic [COORD_W-1:0]        point_z = '0;
    logic                      empty;
    logic                      pop = 1'b0;
    logic [IDX_W-1:0]          row_index;
    logic [IDX_W-1:0]          col_index;
    logic signed [COEFF_W-1:0] coeff;
    logic                      is_diagonal;
    logic [CNT_W-1:0]          row_count;
    logic [CNT_W-1:0]          rhs_value;
    logic                      last;
    logic                      bad_request;

    stencil_row_scoreboard board;

    // Idle shares of the two sides; the main sequence changes them per phase.
    int unsigned push_idle_pct = IDLE_PCT;
    int unsigned pop_idle_pct = IDLE_PCT;
    // Raised once by the main sequence; the result side then stalls on its own.
    bit          hold_request = 1'b0;
    int unsigned grids_used = 0;

    stencil_matrix_row_generator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .empty       (empty),
        .pop         (pop),
        .row_index   (row_index),
        .col_index   (col_index),
        .coeff       (coeff),
        .is_diagonal (is_diagonal),
        .row_count   (row_count),
        .rhs_value   (rhs_value),
        .last        (last),
        .bad_request (bad_request)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Offers one grid point and keeps push high until the block takes the
    // request. Random idle cycles may follow; otherwise push simply stays high
    // and the next call puts the next point behind it without a bubble.
    task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [COORD_W-1:0] z);
        point_x <= x;
        point_y <= y;
        point_z <= z;
        push    <= 1'b1;
        do
            @(posedge clk);
        while (full);
        board.note_point(x, y, z);
        while ($urandom_range(99) < push_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stops offering points and waits until every expected entry has been
    // taken, then lets the block settle. Registers are only written after this.
    task automatic drain_rows();
        push <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write enable stays high across back-to-back writes; the caller lowers it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [SIZE_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        board.write_reg(index, data);
    endtask

    // Loads a whole grid setting once the block is idle.
    task automatic set_grid(input int unsigned sx, input int unsigned sy,
                            input int unsigned sz, input bit seven);
        drain_rows();
        write_reg(REG_SIZE_X, SIZE_W'(sx));
        write_reg(REG_SIZE_Y, SIZE_W'(sy));
        write_reg(REG_SIZE_Z, SIZE_W'(sz));
        write_reg(REG_SEVEN, SIZE_W'(seven));
        cfg_write <= 1'b0;
        grids_used++;
    endtask

    // Random grid size: mostly small grids so that boundaries are hit often,
    // sometimes large or saturating ones, rarely an empty axis.
    function automatic int unsigned pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 3)
            return 0;
        if (r < 15)
            return $urandom_range(200, 511);
        return $urandom_range(1, 6);
    endfunction

    // Random coordinate for an axis of n points: mostly inside the grid with
    // extra weight on the two faces, and a few anywhere in the field's range.
    function automatic logic [COORD_W-1:0] pick_coord(input int unsigned n);
        int unsigned r;
        int unsigned lim;
        r   = $urandom_range(99);
        lim = (n > DEFAULT_MAX_DIM) ? DEFAULT_MAX_DIM : n;
        if (r < 8 || lim == 0)
            return COORD_W'($urandom_range(255));
        if (r < 35)
            return $urandom_range(1) ? COORD_W'(lim - 1) : '0;
        return COORD_W'($urandom_range(lim - 1));
    endfunction

    // Result side. Every result accepted at an edge is checked against the
    // oldest expected entry. Pop idles at random, except during the one long
    // stall, which is counted here so that the sender keeps pushing meanwhile.
    initial
    begin
        int unsigned    hold_left;
        bit             hold_done;
        stencil_entry_t seen;
        hold_left = 0;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                seen.row_index   = row_index;
                seen.col_index   = col_index;
                seen.coeff       = coeff;
                seen.is_diagonal = is_diagonal;
                seen.row_count   = row_count;
                seen.rhs_value   = rhs_value;
                seen.last        = last;
                seen.bad_request = bad_request;
                board.check_entry(seen);
            end
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= pop_idle_pct);
        end
    end

    // Watchdog: any request accepted on either side restarts the count.
    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    // Main sequence: reset, a directed pass over the corner cases, then
    // random phases, each on a fresh grid setting loaded while idle.
    initial
    begin
        int unsigned sx;
        int unsigned sy;
        int unsigned sz;
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset grid is a single point: its row is only the diagonal, and
        // anything off that point is rejected.
        send_point(8'd0, 8'd0, 8'd0);
        send_point(8'd1, 8'd0, 8'd0);
        send_point(8'd0, 8'd0, 8'd255);
        send_point(8'd255, 8'd255, 8'd255);

        // An axis of size zero empties the grid.
        set_grid(0, 4, 4, 1'b0);
        send_point(8'd0, 8'd0, 8'd0);
        send_point(8'd3, 8'd3, 8'd3);

        // Small cube, 27-point: full interior row, corners, an edge, one miss.
        set_grid(3, 3, 3, 1'b0);
        send_point(8'd1, 8'd1, 8'd1);
        send_point(8'd0, 8'd0, 8'd0);
        send_point(8'd2, 8'd2, 8'd2);
        send_point(8'd2, 8'd1, 8'd0);
        send_point(8'd3, 8'd1, 8'd1);

        // Same cube with the 7-point stencil.
        set_grid(3, 3, 3, 1'b1);
        send_point(8'd1, 8'd1, 8'd1);
        send_point(8'd0, 8'd0, 8'd0);
        send_point(8'd2, 8'd0, 8'd1);

        // Sizes above the maximum saturate; the far corner has the top index.
        set_grid(511, 256, 300, 1'b0);
        send_point(8'd255, 8'd255, 8'd255);
        send_point(8'd0, 8'd0, 8'd0);
        send_point(8'd128, 8'd0, 8'd255);
        set_grid(511, 511, 511, 1'b1);
        send_point(8'd255, 8'd0, 8'd128);
        send_point(8'd17, 8'd200, 8'd255);

        // Empty along z only, then a one-dimensional line of points.
        set_grid(256, 1, 0, 1'b0);
        send_point(8'd0, 8'd0, 8'd0);
        set_grid(8, 1, 1, 1'b0);
        send_point(8'd0, 8'd0, 8'd0);
        send_point(8'd7, 8'd0, 8'd0);
        send_point(8'd4, 8'd0, 8'd0);

        // Random phases. Each one starts from a drained block, so the sender
        // pauses at every boundary until all expected results are in.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            sx = pick_size();
            sy = pick_size();
            sz = pick_size();
            set_grid(sx, sy, sz, 1'($urandom_range(1)));
            if (ph == HOLD_PHASE)
                hold_request = 1'b1;
            if (ph == STEADY_PHASE)
            begin
                push_idle_pct = 0;
                pop_idle_pct  = 0;
            end
            else
            begin
                push_idle_pct = IDLE_PCT;
                pop_idle_pct  = IDLE_PCT;
            end
            for (int i = 0; i < PHASE_POINTS; i++)
                send_point(pick_coord(sx), pick_coord(sy), pick_coord(sz));
        end

        drain_rows();
        $display("tb: %0d grid points requested (%0d outside the grid) over %0d grid settings",
                 board.points_noted, board.bad_points_noted, grids_used);
        $display("tb: %0d row entries checked, %0d mismatches",
                 board.entries_checked, board.mismatches);
        if (board.mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
